// ===== hw/rtl/wcs_pkg.sv =====
// Package for the white space and comment skipper.
// Holds the mode, op and result codes, character constants and the queue entry type.
// No dependencies.
package wcs_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0]  CH_SLASH    = 8'h2F;
   localparam logic [7:0]  CH_STAR     = 8'h2A;
   localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
   localparam logic [7:0]  CH_SPACE    = 8'h20;
   localparam logic [7:0]  CH_TAB      = 8'h09;
   localparam logic [7:0]  CH_CR       = 8'h0D;
   localparam logic [8:0]  PREV_NONE   = 9'h100;
   localparam logic [31:0] LINE_MAX    = 32'hFFFF_FFFF;

   localparam logic [7:0]  NESTING_LIMIT_RESET = 8'd255;

   // register indexes of the configuration port
   localparam logic REG_NESTING_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      MODE_IDLE  = 3'd0,
      MODE_SKIP  = 3'd1,
      MODE_SLASH = 3'd2,
      MODE_LINE  = 3'd3,
      MODE_BLOCK = 3'd4,
      MODE_READ  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      OP_SKIP     = 2'd0,
      OP_READ     = 2'd1,
      OP_CHAR     = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      KIND_CONSUMED     = 3'd0,
      KIND_STOP         = 3'd1,
      KIND_IDLE_PASS    = 3'd2,
      KIND_STORED       = 3'd3,
      KIND_END          = 3'd4,
      KIND_UNTERMINATED = 3'd5,
      KIND_TOO_DEEP     = 3'd6
   } kind_type;

   // One queue entry carries the results of one item: one, or two for a lone slash.
   // Both results share the line value; the second always has last low.
   typedef struct packed {
      kind_type    kind0;
      logic [7:0]  char0;
      logic        last0;
      logic [31:0] line;
      logic        two;
      kind_type    kind1;
      logic [7:0]  char1;
   } entry_type;

endpackage

// ===== hw/rtl/wcs_req_if.sv =====
// Input channel of the skipper: valid/ready handshake and one item.
// Uses nothing else.
interface wcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] char_in;
   logic       end_of_input;

   modport source (output valid, output op, output char_in, output end_of_input,
                   input ready);
   modport sink   (input valid, input op, input char_in, input end_of_input,
                   output ready);
endinterface

// ===== hw/rtl/wcs_rsp_if.sv =====
// Result channel of the skipper: valid/ready handshake and one result.
// Uses nothing else.
interface wcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  char_out;
   logic        last;
   logic [31:0] line;

   modport source (output valid, output kind, output char_out, output last, output line,
                   input ready);
   modport sink   (input valid, input kind, input char_out, input last, input line,
                   output ready);
endinterface

// ===== hw/rtl/wcs_front.sv =====
// Front end of the skipper: accepts transactions, runs the mode machine and
// pushes the results of each item into the queue. Depends on wcs_pkg, wcs_req_if.
module wcs_front (
   input  logic                clock,
   input  logic                reset,
   wcs_req_if.sink             req,
   input  logic [7:0]          nesting_limit,
   input  logic                queue_full,
   output logic                push,
   output wcs_pkg::entry_type  push_entry
);

   wcs_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        depth_ff, depth_in;
   logic [8:0]        prev_ff, prev_in;
   logic [31:0]       line_ff, line_in;
   logic [31:0]       start_line_ff, start_line_in;

   logic        accept;
   logic [7:0]  c;
   logic        eoi;
   logic        is_nl;
   logic        is_white;
   logic [31:0] line_next;
   logic        opening;
   logic        closing;
   logic        unterm;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.char_in;
   assign eoi       = req.end_of_input;
   assign is_nl     = (c == wcs_pkg::CH_NEWLINE);
   assign is_white  = (c == wcs_pkg::CH_SPACE) ||
                      ((c >= wcs_pkg::CH_TAB) && (c <= wcs_pkg::CH_CR));
   assign line_next = (line_ff != wcs_pkg::LINE_MAX) ? line_ff + 32'd1 : line_ff;
   assign opening   = (prev_ff == {1'b0, wcs_pkg::CH_SLASH}) && (c == wcs_pkg::CH_STAR);
   assign closing   = (prev_ff == {1'b0, wcs_pkg::CH_STAR}) && (c == wcs_pkg::CH_SLASH);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= wcs_pkg::MODE_IDLE;
         depth_ff      <= '0;
         prev_ff       <= wcs_pkg::PREV_NONE;
         line_ff       <= '0;
         start_line_ff <= '0;
      end else begin
         mode_ff       <= mode_in;
         depth_ff      <= depth_in;
         prev_ff       <= prev_in;
         line_ff       <= line_in;
         start_line_ff <= start_line_in;
      end
   end

   always_comb begin
      mode_in             = mode_ff;
      depth_in            = depth_ff;
      prev_in             = prev_ff;
      line_in             = line_ff;
      start_line_in       = start_line_ff;
      unterm              = 1'b0;
      push                = 1'b0;
      push_entry.kind0    = wcs_pkg::KIND_CONSUMED;
      push_entry.char0    = c;
      push_entry.last0    = 1'b0;
      push_entry.line     = line_ff;
      push_entry.two      = 1'b0;
      push_entry.kind1    = wcs_pkg::KIND_IDLE_PASS;
      push_entry.char1    = c;
      if (accept) begin
         unique case (wcs_pkg::op_type'(req.op))
            wcs_pkg::OP_SKIP: begin
               mode_in  = wcs_pkg::MODE_SKIP;
               depth_in = '0;
               prev_in  = wcs_pkg::PREV_NONE;
            end
            wcs_pkg::OP_READ: begin
               mode_in       = wcs_pkg::MODE_READ;
               depth_in      = 8'd1;
               prev_in       = wcs_pkg::PREV_NONE;
               start_line_in = line_ff;
            end
            wcs_pkg::OP_RESERVED: begin
            end
            wcs_pkg::OP_CHAR: begin
               push = 1'b1;
               unique case (mode_ff)
                  wcs_pkg::MODE_SKIP: begin
                     if (eoi) begin
                        mode_in          = wcs_pkg::MODE_IDLE;
                        push_entry.kind0 = wcs_pkg::KIND_END;
                        push_entry.char0 = '0;
                        push_entry.last0 = 1'b1;
                     end else if (is_white) begin
                        if (is_nl) line_in = line_next;
                     end else if (c == wcs_pkg::CH_SLASH) begin
                        mode_in = wcs_pkg::MODE_SLASH;
                     end else begin
                        mode_in          = wcs_pkg::MODE_IDLE;
                        push_entry.kind0 = wcs_pkg::KIND_STOP;
                        push_entry.last0 = 1'b1;
                     end
                  end
                  wcs_pkg::MODE_SLASH: begin
                     if (!eoi && c == wcs_pkg::CH_SLASH) begin
                        mode_in = wcs_pkg::MODE_LINE;
                     end else if (!eoi && c == wcs_pkg::CH_STAR) begin
                        mode_in       = wcs_pkg::MODE_BLOCK;
                        depth_in      = 8'd1;
                        prev_in       = wcs_pkg::PREV_NONE;
                        start_line_in = line_ff;
                     end else begin
                        // lone slash: report it, then pass the next character through
                        mode_in          = wcs_pkg::MODE_IDLE;
                        push_entry.kind0 = wcs_pkg::KIND_STOP;
                        push_entry.char0 = wcs_pkg::CH_SLASH;
                        push_entry.last0 = 1'b1;
                        push_entry.two   = 1'b1;
                        push_entry.kind1 = eoi ? wcs_pkg::KIND_END : wcs_pkg::KIND_IDLE_PASS;
                        push_entry.char1 = eoi ? 8'd0 : c;
                     end
                  end
                  wcs_pkg::MODE_LINE: begin
                     if (eoi) begin
                        mode_in          = wcs_pkg::MODE_IDLE;
                        push_entry.kind0 = wcs_pkg::KIND_END;
                        push_entry.char0 = '0;
                        push_entry.last0 = 1'b1;
                     end else if (is_nl) begin
                        line_in = line_next;
                        mode_in = wcs_pkg::MODE_SKIP;
                     end
                  end
                  wcs_pkg::MODE_BLOCK,
                  wcs_pkg::MODE_READ: begin
                     if (mode_ff == wcs_pkg::MODE_READ) push_entry.kind0 = wcs_pkg::KIND_STORED;
                     if (eoi) begin
                        mode_in          = wcs_pkg::MODE_IDLE;
                        unterm           = 1'b1;
                        push_entry.kind0 = wcs_pkg::KIND_UNTERMINATED;
                        push_entry.char0 = '0;
                        push_entry.last0 = 1'b1;
                     end else begin
                        if (is_nl) line_in = line_next;
                        if (opening) begin
                           prev_in = wcs_pkg::PREV_NONE;
                           if (depth_ff >= nesting_limit) begin
                              mode_in          = wcs_pkg::MODE_IDLE;
                              push_entry.kind0 = wcs_pkg::KIND_TOO_DEEP;
                              push_entry.last0 = 1'b1;
                           end else begin
                              depth_in = depth_ff + 8'd1;
                           end
                        end else if (closing) begin
                           prev_in  = wcs_pkg::PREV_NONE;
                           depth_in = depth_ff - 8'd1;
                           if (depth_ff == 8'd1) begin
                              if (mode_ff == wcs_pkg::MODE_READ) begin
                                 mode_in          = wcs_pkg::MODE_IDLE;
                                 push_entry.last0 = 1'b1;
                              end else begin
                                 mode_in = wcs_pkg::MODE_SKIP;
                              end
                           end
                        end else begin
                           prev_in = {1'b0, c};
                        end
                     end
                  end
                  default: begin
                     push_entry.kind0 = wcs_pkg::KIND_IDLE_PASS;
                     push_entry.char0 = eoi ? 8'd0 : c;
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
      push_entry.line = unterm ? start_line_ff : line_in;
   end

   // inside a block comment the depth is never zero
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == wcs_pkg::MODE_BLOCK || mode_ff == wcs_pkg::MODE_READ) |-> depth_ff != 8'd0)
      else $error("block comment mode with zero depth");

   // the line counter only moves forward
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> line_ff >= $past(line_ff))
      else $error("line counter went backward");

endmodule

// ===== hw/rtl/wcs_queue.sv =====
// Queue between front and back ends; one entry holds the results of one item.
// Depends on wcs_pkg.
module wcs_queue #(
   parameter int DEPTH = wcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wcs_pkg::entry_type  push_entry,
   output logic                full,
   output logic                head_valid,
   output wcs_pkg::entry_type  head_entry,
   input  logic                pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   wcs_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (!push && pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_entry;
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

// ===== hw/rtl/wcs_back.sv =====
// Back end of the skipper: drains queue entries into the output register,
// splitting a two-result entry over two transactions. Depends on wcs_pkg, wcs_rsp_if.
module wcs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  wcs_pkg::entry_type  head_entry,
   output logic                pop,
   wcs_rsp_if.source           rsp
);

   logic              valid_ff, valid_in;
   logic              two_ff, two_in;
   wcs_pkg::kind_type kind_ff, kind_in;
   logic [7:0]        char_ff, char_in;
   logic              last_ff, last_in;
   logic [31:0]       line_ff, line_in;
   wcs_pkg::kind_type kind2_ff, kind2_in;
   logic [7:0]        char2_ff, char2_in;
   logic              slot_free;

   assign slot_free = !valid_ff || rsp.ready;
   assign pop       = slot_free && !two_ff && head_valid;

   always_comb begin
      valid_in = valid_ff;
      two_in   = two_ff;
      kind_in  = kind_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      line_in  = line_ff;
      kind2_in = kind2_ff;
      char2_in = char2_ff;
      if (slot_free) begin
         if (two_ff) begin
            // second result of a lone slash; line stays as it was
            valid_in = 1'b1;
            two_in   = 1'b0;
            kind_in  = kind2_ff;
            char_in  = char2_ff;
            last_in  = 1'b0;
         end else if (head_valid) begin
            valid_in = 1'b1;
            two_in   = head_entry.two;
            kind_in  = head_entry.kind0;
            char_in  = head_entry.char0;
            last_in  = head_entry.last0;
            line_in  = head_entry.line;
            kind2_in = head_entry.kind1;
            char2_in = head_entry.char1;
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         two_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         two_ff   <= two_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
      line_ff  <= line_in;
      kind2_ff <= kind2_in;
      char2_ff <= char2_in;
   end

   assign rsp.valid    = valid_ff;
   assign rsp.kind     = kind_ff;
   assign rsp.char_out = char_ff;
   assign rsp.last     = last_ff;
   assign rsp.line     = line_ff;

   // a pending second result always sits behind a shown first one
   assert property (@(posedge clock) disable iff (reset) two_ff |-> valid_ff)
      else $error("second result pending without a first");

endmodule

// ===== hw/rtl/whitespace_comment_skipper.sv =====
// White space and comment skipper, top level. Takes one character per
// transaction and passes over white space, line comments and nestable block
// comments, reporting each character with a result code and a saturating line
// count; a lone slash yields two results. Items are taken one per cycle back to
// back: the front end decides each item combinationally and writes its results
// into a QUEUE_DEPTH-entry queue; the back end shows one result per cycle when
// not stalled, so a lone slash costs one more output. The input stalls only
// when the queue is full. The nesting limit sits at address 0 of the APB port.
// Depends on wcs_pkg, wcs_req_if, wcs_rsp_if, wcs_front, wcs_queue, wcs_back.
module whitespace_comment_skipper #(
   parameter int QUEUE_DEPTH = wcs_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   wcs_req_if.sink     req,
   wcs_rsp_if.source   rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]         nesting_limit_ff, nesting_limit_in;
   logic               csr_write;
   logic               push;
   logic               queue_full;
   logic               head_valid;
   logic               pop;
   wcs_pkg::entry_type push_entry;
   wcs_pkg::entry_type head_entry;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      nesting_limit_in = nesting_limit_ff;
      if (csr_write && csr_paddr[2] == wcs_pkg::REG_NESTING_LIMIT) begin
         nesting_limit_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) nesting_limit_ff <= wcs_pkg::NESTING_LIMIT_RESET;
      else       nesting_limit_ff <= nesting_limit_in;
   end

   assign csr_prdata = (csr_paddr[2] == wcs_pkg::REG_NESTING_LIMIT) ?
                       {24'd0, nesting_limit_ff} : 32'd0;

   wcs_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .nesting_limit (nesting_limit_ff),
      .queue_full    (queue_full),
      .push          (push),
      .push_entry    (push_entry)
   );

   wcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop)
   );

   wcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule
